### hw/rtl/dapt_pkg.sv
// shared constants, types and arithmetic settings for the pulsed tilt controller
package dapt_pkg;

  // field widths
  localparam int AngleW = 9;
  localparam int PosW   = 12;
  localparam int ErrW   = PosW + 1;
  localparam int TimeW  = 32;
  localparam int MsW    = 16;
  localparam int OutW   = 11;

  // mechanical angle range that the configured angles are scaled from
  localparam int LowerLimit = 0;
  localparam int UpperLimit = 180;
  localparam int ScaleDiv   = UpperLimit - LowerLimit;

  // scaling datapath widths
  localparam int OffsW = AngleW + 1;
  localparam int DiffW = AngleW + 1;
  localparam int ProdW = OffsW + DiffW;
  localparam int MagW  = ProdW - 2;

  // exact truncating divide by ScaleDiv: q = (mag * Recip) >> RecipShift for mag < 2**MagW
  localparam int RecipShift = MagW + $clog2(ScaleDiv);
  localparam int RecipW     = RecipShift + 1;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((longint'(1) << RecipShift) + longint'(ScaleDiv) - 1) / longint'(ScaleDiv));

  // stream and register port widths
  localparam int InDataW  = 80;
  localparam int OutDataW = 32;
  localparam int AddrW    = 5;
  localparam int ApbDataW = 32;

  // register indexes
  localparam logic [2:0] RegOutMin  = 3'd0;
  localparam logic [2:0] RegOutMax  = 3'd1;
  localparam logic [2:0] RegOutZero = 3'd2;
  localparam logic [2:0] RegDelay   = 3'd3;
  localparam logic [2:0] RegAction  = 3'd4;
  localparam logic [2:0] RegMinErr  = 3'd5;

  // register reset values
  localparam logic signed [AngleW-1:0] OutMinRst  = -9'sd15;
  localparam logic signed [AngleW-1:0] OutMaxRst  = 9'sd15;
  localparam logic signed [AngleW-1:0] OutZeroRst = 9'sd0;
  localparam logic [MsW-1:0]           DelayRst   = 16'd100;
  localparam logic [MsW-1:0]           ActionRst  = 16'd50;
  localparam logic [PosW-1:0]          MinErrRst  = 12'd10;

  // result item layout in m_axis_tdata
  localparam int OutXLsb    = 0;
  localparam int OutYLsb    = OutW;
  localparam int OutAxisLsb = 2 * OutW;
  localparam int OutAtLsb   = 2 * OutW + 2;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2
  } axis_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_MIN  = 2'd1,
    SEL_MAX  = 2'd2
  } angle_sel_e;

endpackage

### hw/rtl/dapt_scale.sv
// divide a scaled angle product by the angle range, truncate toward zero and saturate
module dapt_scale
  import dapt_pkg::*;
(
  input  logic signed [ProdW-1:0] prod_i,
  output logic signed [OutW-1:0]  angle_o
);

  localparam logic [MagW-1:0] SatPos = MagW'((1 << (OutW - 1)) - 1);
  localparam logic [MagW-1:0] SatNeg = MagW'(1 << (OutW - 1));

  logic                     neg;
  logic [ProdW-1:0]         mag_full;
  logic [MagW-1:0]          mag;
  logic [MagW+RecipW-1:0]   full;
  logic [MagW-1:0]          quo;

  assign neg      = prod_i[ProdW-1];
  assign mag_full = neg ? ProdW'(-prod_i) : ProdW'(prod_i);
  assign mag      = mag_full[MagW-1:0];

  // reciprocal multiply, exact for every magnitude below 2**MagW
  assign full = {{RecipW{1'b0}}, mag} * {{MagW{1'b0}}, Recip};
  assign quo  = full[RecipShift +: MagW];

  always_comb begin
    if (!neg) begin
      if (quo > SatPos) begin
        angle_o = {1'b0, {(OutW-1){1'b1}}};
      end else begin
        angle_o = quo[OutW-1:0];
      end
    end else begin
      if (quo > SatNeg) begin
        angle_o = {1'b1, {(OutW-1){1'b0}}};
      end else begin
        angle_o = OutW'(~quo[OutW-1:0] + 1'b1);
      end
    end
  end

endmodule

### hw/rtl/dual_axis_pulsed_tilt_controller.sv
// top level of the dual-axis pulsed tilt controller
//
// usage
//   s_axis carries one item per camera frame: target and measured ball position
//   for x and y plus a millisecond timestamp. m_axis returns one result item per
//   input item: scaled x and y tilt commands, the axis now driven and an
//   at-target flag. the apb port holds six settings (angles, pulse timing,
//   settle threshold) at byte addresses 0, 4, .. 20; write only while idle.
// timing
//   three register stages: input, product, result. one item per cycle is
//   sustained while m_axis_tready is high, because the axis and pulse timer
//   state is updated in the single product stage. the scaling uses one 10x10
//   multiply before the product register and one reciprocal multiply before
//   the result register, per axis.
// reset
//   settings return to their defaults, no axis is driven, the pulse timer is
//   cleared so the next driven axis tilts at once, and all stages are empty.
// stall
//   when m_axis_tready is low the result holds; the stages behind it keep
//   filling, so up to three items are held before s_axis_tready drops.
module dual_axis_pulsed_tilt_controller
  import dapt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // desired_x[11:0], desired_y[23:12], current_x[35:24], current_y[47:36], time_ms[79:48]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // x_angle[10:0], y_angle[21:11], active_axis[23:22], at_target[24], zero[31:25]
  output logic [OutDataW-1:0] m_axis_tdata,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // settings registers
  // ---------------------------------------------------------------------------
  logic signed [AngleW-1:0] out_min_q, out_max_q, out_zero_q;
  logic [MsW-1:0]           delay_q, action_q;
  logic [PosW-1:0]          min_err_q;
  logic                     cfg_we;
  logic [2:0]               reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_min_q  <= OutMinRst;
      out_max_q  <= OutMaxRst;
      out_zero_q <= OutZeroRst;
      delay_q    <= DelayRst;
      action_q   <= ActionRst;
      min_err_q  <= MinErrRst;
    end else if (cfg_we) begin
      case (reg_idx)
        RegOutMin:  out_min_q  <= pwdata[AngleW-1:0];
        RegOutMax:  out_max_q  <= pwdata[AngleW-1:0];
        RegOutZero: out_zero_q <= pwdata[AngleW-1:0];
        RegDelay:   delay_q    <= pwdata[MsW-1:0];
        RegAction:  action_q   <= pwdata[MsW-1:0];
        RegMinErr:  min_err_q  <= pwdata[PosW-1:0];
        default:    ; // unmapped address, write dropped
      endcase
    end
  end

  // read back, angles sign extended
  always_comb begin
    unique case (reg_idx)
      RegOutMin:  prdata = ApbDataW'(out_min_q);
      RegOutMax:  prdata = ApbDataW'(out_max_q);
      RegOutZero: prdata = ApbDataW'(out_zero_q);
      RegDelay:   prdata = ApbDataW'(delay_q);
      RegAction:  prdata = ApbDataW'(action_q);
      RegMinErr:  prdata = ApbDataW'(min_err_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // stage handshake: each stage moves when the one ahead is empty or moving
  // ---------------------------------------------------------------------------
  logic in_v_q, mid_v_q, out_v_q;
  logic in_adv, mid_adv, out_adv;

  assign out_adv       = !out_v_q || m_axis_tready;
  assign mid_adv       = !mid_v_q || out_adv;
  assign in_adv        = !in_v_q  || mid_adv;
  assign s_axis_tready = in_adv;
  assign m_axis_tvalid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_v_q <= s_axis_tvalid;
      end
      if (mid_adv) begin
        mid_v_q <= in_v_q;
      end
      if (out_adv) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]  in_dx_q, in_dy_q, in_cx_q, in_cy_q;
  logic [TimeW-1:0] in_time_q;

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_dx_q   <= s_axis_tdata[11:0];
      in_dy_q   <= s_axis_tdata[23:12];
      in_cx_q   <= s_axis_tdata[35:24];
      in_cy_q   <= s_axis_tdata[47:36];
      in_time_q <= s_axis_tdata[79:48];
    end
  end

  // ---------------------------------------------------------------------------
  // decision logic: errors, axis selection and pulse timing
  // ---------------------------------------------------------------------------
  logic signed [ErrW-1:0] err_x, err_y;
  logic [ErrW-1:0]        abs_x, abs_y;
  logic                   x_ok, y_ok;
  angle_sel_e             x_drive, y_drive;

  assign err_x = $signed({1'b0, in_dx_q}) - $signed({1'b0, in_cx_q});
  assign err_y = $signed({1'b0, in_dy_q}) - $signed({1'b0, in_cy_q});
  assign abs_x = err_x[ErrW-1] ? ErrW'(-err_x) : ErrW'(err_x);
  assign abs_y = err_y[ErrW-1] ? ErrW'(-err_y) : ErrW'(err_y);
  assign x_ok  = abs_x <= {1'b0, min_err_q};
  assign y_ok  = abs_y <= {1'b0, min_err_q};

  // x tilts toward min for a positive error, y toward max
  assign x_drive = (!err_x[ErrW-1] && err_x != '0) ? SEL_MIN : SEL_MAX;
  assign y_drive = (!err_y[ErrW-1] && err_y != '0) ? SEL_MAX : SEL_MIN;

  axis_e            axis_q, axis_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             cleared_q, cleared_d;
  logic [TimeW-1:0] elapsed;
  logic [MsW:0]     period;
  logic             in_tilt, in_level, restart;
  logic             pulse_used;
  angle_sel_e       x_sel, y_sel;

  // position in the tilt / level cycle, wrapping timestamps
  assign elapsed  = in_time_q - start_q;
  assign period   = {1'b0, action_q} + {1'b0, delay_q};
  assign in_tilt  = !cleared_q && (elapsed <= TimeW'(action_q));
  assign in_level = !cleared_q && !in_tilt && (elapsed <= TimeW'(period));
  assign restart  = !in_tilt && !in_level;

  always_comb begin
    axis_d     = axis_q;
    start_d    = start_q;
    cleared_d  = cleared_q;
    x_sel      = SEL_ZERO;
    y_sel      = SEL_ZERO;
    pulse_used = 1'b0;
    unique case (axis_q)
      AXIS_X: begin
        if (x_ok) begin
          axis_d    = AXIS_NONE;
          start_d   = '0;
          cleared_d = 1'b1;
        end else begin
          x_sel      = in_level ? SEL_ZERO : x_drive;
          pulse_used = 1'b1;
        end
      end
      AXIS_Y: begin
        if (y_ok) begin
          axis_d    = AXIS_NONE;
          start_d   = '0;
          cleared_d = 1'b1;
        end else begin
          y_sel      = in_level ? SEL_ZERO : y_drive;
          pulse_used = 1'b1;
        end
      end
      default: begin
        // no axis driven: x has priority
        if (!x_ok) begin
          axis_d     = AXIS_X;
          x_sel      = in_level ? SEL_ZERO : x_drive;
          pulse_used = 1'b1;
        end else if (!y_ok) begin
          axis_d     = AXIS_Y;
          y_sel      = in_level ? SEL_ZERO : y_drive;
          pulse_used = 1'b1;
        end else begin
          axis_d = AXIS_NONE;
        end
      end
    endcase
    // a new pulse starts on this frame
    if (pulse_used && restart) begin
      start_d   = in_time_q;
      cleared_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q    <= AXIS_NONE;
      start_q   <= '0;
      cleared_q <= 1'b1;
    end else if (in_v_q && mid_adv) begin
      axis_q    <= axis_d;
      start_q   <= start_d;
      cleared_q <= cleared_d;
    end
  end

  // ---------------------------------------------------------------------------
  // scaling numerator: (angle - lower limit) * (max - min)
  // ---------------------------------------------------------------------------
  logic signed [AngleW-1:0] x_ang, y_ang;
  logic signed [OffsW-1:0]  x_offs, y_offs;
  logic signed [DiffW-1:0]  span;
  logic signed [ProdW-1:0]  x_prod, y_prod;

  always_comb begin
    case (x_sel)
      SEL_MIN: x_ang = out_min_q;
      SEL_MAX: x_ang = out_max_q;
      default: x_ang = out_zero_q;
    endcase
    case (y_sel)
      SEL_MIN: y_ang = out_min_q;
      SEL_MAX: y_ang = out_max_q;
      default: y_ang = out_zero_q;
    endcase
  end

  assign span   = DiffW'(out_max_q) - DiffW'(out_min_q);
  assign x_offs = OffsW'(x_ang) - OffsW'(LowerLimit);
  assign y_offs = OffsW'(y_ang) - OffsW'(LowerLimit);
  assign x_prod = ProdW'(x_offs) * ProdW'(span);
  assign y_prod = ProdW'(y_offs) * ProdW'(span);

  // ---------------------------------------------------------------------------
  // product register
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] mid_xprod_q, mid_yprod_q;
  axis_e                   mid_axis_q;
  logic                    mid_at_q;

  always_ff @(posedge clk_i) begin
    if (mid_adv && in_v_q) begin
      mid_xprod_q <= x_prod;
      mid_yprod_q <= y_prod;
      mid_axis_q  <= axis_d;
      mid_at_q    <= x_ok && y_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // divide, saturate and result register
  // ---------------------------------------------------------------------------
  logic signed [OutW-1:0] x_scaled, y_scaled;

  dapt_scale u_scale_x (
    .prod_i  (mid_xprod_q),
    .angle_o (x_scaled)
  );

  dapt_scale u_scale_y (
    .prod_i  (mid_yprod_q),
    .angle_o (y_scaled)
  );

  logic signed [OutW-1:0] out_x_q, out_y_q;
  axis_e                  out_axis_q;
  logic                   out_at_q;

  always_ff @(posedge clk_i) begin
    if (out_adv && mid_v_q) begin
      out_x_q    <= x_scaled;
      out_y_q    <= y_scaled;
      out_axis_q <= mid_axis_q;
      out_at_q   <= mid_at_q;
    end
  end

  assign m_axis_tdata = {{(OutDataW - OutAtLsb - 1){1'b0}}, out_at_q, out_axis_q,
                         out_y_q, out_x_q};

endmodule

### hw/rtl/dapt_checker.sv
// port-level checks for the pulsed tilt controller, bound to the top level
module dapt_checker
  import dapt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [OutW-1:0] x_angle, y_angle;
  logic [1:0]      active_axis;
  logic            at_target;

  assign x_angle     = m_axis_tdata[OutXLsb +: OutW];
  assign y_angle     = m_axis_tdata[OutYLsb +: OutW];
  assign active_axis = m_axis_tdata[OutAxisLsb +: 2];
  assign at_target   = m_axis_tdata[OutAtLsb];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // both axes settled means nothing is driven
  a_target_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && at_target |-> active_axis == AXIS_NONE)
    else $error("axis driven while at target");

  // with no axis driven both commands are the scaled level angle
  a_idle_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && active_axis == AXIS_NONE |-> x_angle == y_angle)
    else $error("idle axes disagree");

  // input only backs up when the result side is stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

endmodule

bind dual_axis_pulsed_tilt_controller dapt_checker u_dapt_checker (.*);
